### rtl/kxrd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kxrd_pkg
// Shared types, constants and helpers of the keyed XOR run-length decoder.
// ----------------------------------------------------------------------------
package kxrd_pkg;

  localparam int PIX_W = 28;

  localparam logic [31:0] STEP_MUL  = 32'h2d83cdac;
  localparam logic [31:0] STEP_ADD  = 32'hd8a83423;
  localparam logic [31:0] LAYER_MUL = 32'h1e1530cd;
  localparam logic [31:0] LAYER_ADD = 32'hec3d47cd;

  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_CIPHER_SEED  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LAYER_PIXELS = 8'd1;

  // One decoded byte, handed from the front to the back
  typedef struct packed {
    logic             layer_start;
    logic             layer_stop;
    logic             full_now;
    logic             run_valid;
    logic [6:0]       run_code;
    logic [PIX_W-1:0] run_len;
  } cmd_t;

  // Back status seen by the front
  typedef struct packed {
    logic             idle;
    logic             layer_full;
    logic [PIX_W-1:0] pixel_pos;
  } bk_stat_t;

  typedef struct packed {
    logic [7:0]       grey_level;
    logic [PIX_W-1:0] run_pixels;
    logic             final_run;
  } res_t;

  function automatic logic [7:0] grey_of(input logic [6:0] code);
    grey_of = (code == 7'd0) ? 8'd0 : {code, 1'b1};
  endfunction

endpackage

### rtl/kxrd_cmd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kxrd_cmd_queue
// Two-entry queue of decoded commands between the front and the back.
// ----------------------------------------------------------------------------
module kxrd_cmd_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  kxrd_pkg::cmd_t push_data,
  input  logic          pop,
  output kxrd_pkg::cmd_t head,
  output logic          q_empty,
  output logic          q_full
);
  import kxrd_pkg::*;

  cmd_t       mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign q_empty = (cnt_r == 2'd0);
  assign q_full  = (cnt_r == 2'd2);
  assign head    = mem_r[rd_ptr_r];
  assign do_push = push && !q_full;
  assign do_pop  = pop && !q_empty;

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

### rtl/kxrd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kxrd_front
// Accepts bytes, derives the layer key, decrypts and parses the stream into
// run commands.
// ----------------------------------------------------------------------------
module kxrd_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_push,
  output logic                    in_full,
  input  logic [7:0]              in_code_byte,
  input  logic                    in_layer_begin,
  input  logic                    in_layer_end,
  input  logic [15:0]             in_layer_number,
  input  logic [31:0]             cipher_seed,
  input  logic [kxrd_pkg::PIX_W-1:0] layer_pixels,
  input  kxrd_pkg::bk_stat_t      bk_stat,
  input  logic                    q_empty,
  input  logic                    q_full,
  output logic                    q_push,
  output kxrd_pkg::cmd_t          q_data
);
  import kxrd_pkg::*;

  localparam logic [2:0] F_IDLE = 3'd0;
  localparam logic [2:0] F_STEP = 3'd1;
  localparam logic [2:0] F_BASE = 3'd2;
  localparam logic [2:0] F_KEY  = 3'd3;
  localparam logic [2:0] F_PROC = 3'd4;

  localparam logic [1:0] PH_CODE = 2'd0;
  localparam logic [1:0] PH_LEN  = 2'd1;
  localparam logic [1:0] PH_EXT  = 2'd2;

  logic [2:0]       state_r, state_nxt;
  logic [7:0]       byte_r, byte_nxt;
  logic             start_r, start_nxt;
  logic             stop_r, stop_nxt;
  logic [15:0]      layer_r, layer_nxt;
  logic [31:0]      key_word_r, key_word_nxt;
  logic [31:0]      key_step_r, key_step_nxt;
  logic [1:0]       key_pos_r, key_pos_nxt;
  logic [1:0]       phase_r, phase_nxt;
  logic [6:0]       held_r, held_nxt;
  logic [PIX_W-1:0] accum_r, accum_nxt;
  logic [1:0]       ext_left_r, ext_left_nxt;

  logic             accept;
  logic             full_now;
  logic [7:0]       key_byte;
  logic [7:0]       b;
  logic [PIX_W-1:0] accum_sh;
  logic [1:0]       ext_dec;
  cmd_t             cmd;

  assign in_full = !((state_r == F_IDLE) && q_empty && bk_stat.idle);
  assign accept  = in_push && !in_full;

  always_comb begin
    unique case (key_pos_r)
      2'd0: key_byte = key_word_r[7:0];
      2'd1: key_byte = key_word_r[15:8];
      2'd2: key_byte = key_word_r[23:16];
      2'd3: key_byte = key_word_r[31:24];
      default: key_byte = key_word_r[7:0];
    endcase
  end

  assign b        = byte_r ^ key_byte;
  assign accum_sh = {accum_r[PIX_W-9:0], b};
  assign ext_dec  = ext_left_r - 2'd1;
  assign full_now = start_r ? (layer_pixels == '0)
                            : (bk_stat.layer_full || (bk_stat.pixel_pos >= layer_pixels));

  always_comb begin
    state_nxt    = state_r;
    byte_nxt     = byte_r;
    start_nxt    = start_r;
    stop_nxt     = stop_r;
    layer_nxt    = layer_r;
    key_word_nxt = key_word_r;
    key_step_nxt = key_step_r;
    key_pos_nxt  = key_pos_r;
    phase_nxt    = phase_r;
    held_nxt     = held_r;
    accum_nxt    = accum_r;
    ext_left_nxt = ext_left_r;
    cmd          = '0;
    q_push       = 1'b0;

    unique case (state_r)
      F_IDLE: begin
        if (accept) begin
          byte_nxt  = in_code_byte;
          start_nxt = in_layer_begin;
          stop_nxt  = in_layer_end;
          layer_nxt = in_layer_number;
          state_nxt = F_PROC;
          if (in_layer_begin) begin
            phase_nxt    = PH_CODE;
            held_nxt     = '0;
            accum_nxt    = '0;
            ext_left_nxt = '0;
            key_pos_nxt  = '0;
            if (cipher_seed != 32'd0) begin
              state_nxt = F_STEP;
            end else begin
              key_word_nxt = '0;
              key_step_nxt = '0;
            end
          end
        end
      end
      F_STEP: begin
        key_step_nxt = cipher_seed * STEP_MUL + STEP_ADD;
        state_nxt    = F_BASE;
      end
      F_BASE: begin
        // hold the layer term in the key word until the final product
        key_word_nxt = {16'd0, layer_r} * LAYER_MUL + LAYER_ADD;
        state_nxt    = F_KEY;
      end
      F_KEY: begin
        key_word_nxt = key_word_r * key_step_r;
        state_nxt    = F_PROC;
      end
      F_PROC: begin
        cmd.layer_start = start_r;
        cmd.layer_stop  = stop_r;
        cmd.full_now    = full_now;
        if (!full_now) begin
          key_pos_nxt = key_pos_r + 2'd1;
          if (key_pos_r == 2'd3) begin
            key_word_nxt = key_word_r + key_step_r;
          end
          unique case (phase_r)
            PH_CODE: begin
              if (!b[7]) begin
                cmd.run_valid = 1'b1;
                cmd.run_code  = b[6:0];
                cmd.run_len   = PIX_W'(1);
              end else begin
                held_nxt  = b[6:0];
                phase_nxt = PH_LEN;
              end
            end
            PH_LEN: begin
              priority if (!b[7]) begin
                phase_nxt     = PH_CODE;
                cmd.run_valid = 1'b1;
                cmd.run_code  = held_r;
                cmd.run_len   = {{(PIX_W-7){1'b0}}, b[6:0]};
              end else if (!b[6]) begin
                accum_nxt    = {{(PIX_W-6){1'b0}}, b[5:0]};
                ext_left_nxt = 2'd1;
                phase_nxt    = PH_EXT;
              end else if (!b[5]) begin
                accum_nxt    = {{(PIX_W-5){1'b0}}, b[4:0]};
                ext_left_nxt = 2'd2;
                phase_nxt    = PH_EXT;
              end else if (!b[4]) begin
                accum_nxt    = {{(PIX_W-4){1'b0}}, b[3:0]};
                ext_left_nxt = 2'd3;
                phase_nxt    = PH_EXT;
              end else begin
                // escape prefix: single pixel
                phase_nxt     = PH_CODE;
                cmd.run_valid = 1'b1;
                cmd.run_code  = held_r;
                cmd.run_len   = PIX_W'(1);
              end
            end
            PH_EXT: begin
              accum_nxt    = accum_sh;
              ext_left_nxt = ext_dec;
              if (ext_dec == 2'd0) begin
                phase_nxt     = PH_CODE;
                cmd.run_valid = 1'b1;
                cmd.run_code  = held_r;
                cmd.run_len   = accum_sh;
              end
            end
            default: begin
              phase_nxt = PH_CODE;
            end
          endcase
        end
        if (stop_r) begin
          // drop any partial code
          phase_nxt    = PH_CODE;
          accum_nxt    = '0;
          ext_left_nxt = '0;
        end
        if (!q_full) begin
          q_push    = 1'b1;
          state_nxt = F_IDLE;
        end else begin
          key_pos_nxt  = key_pos_r;
          key_word_nxt = key_word_r;
          phase_nxt    = phase_r;
          held_nxt     = held_r;
          accum_nxt    = accum_r;
          ext_left_nxt = ext_left_r;
        end
      end
      default: begin
        state_nxt = F_IDLE;
      end
    endcase
  end

  assign q_data = cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= F_IDLE;
      key_word_r <= '0;
      key_step_r <= '0;
      key_pos_r  <= '0;
      phase_r    <= PH_CODE;
      held_r     <= '0;
      accum_r    <= '0;
      ext_left_r <= '0;
    end else begin
      state_r    <= state_nxt;
      key_word_r <= key_word_nxt;
      key_step_r <= key_step_nxt;
      key_pos_r  <= key_pos_nxt;
      phase_r    <= phase_nxt;
      held_r     <= held_nxt;
      accum_r    <= accum_nxt;
      ext_left_r <= ext_left_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r  <= byte_nxt;
    start_r <= start_nxt;
    stop_r  <= stop_nxt;
    layer_r <= layer_nxt;
  end

endmodule

### rtl/kxrd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kxrd_back
// Clips runs to the pixels left in the layer, closes layers and queues the
// resulting runs for the consumer.
// ----------------------------------------------------------------------------
module kxrd_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [kxrd_pkg::PIX_W-1:0] layer_pixels,
  input  kxrd_pkg::cmd_t             q_head,
  input  logic                       q_empty,
  output logic                       q_pop,
  output kxrd_pkg::bk_stat_t         bk_stat,
  output logic                       out_empty,
  input  logic                       out_pop,
  output kxrd_pkg::res_t             out_res
);
  import kxrd_pkg::*;

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_LEFT = 2'd1;
  localparam logic [1:0] B_RUN  = 2'd2;
  localparam logic [1:0] B_END  = 2'd3;

  logic [1:0]       state_r, state_nxt;
  cmd_t             cmd_r, cmd_nxt;
  logic [PIX_W-1:0] pixel_pos_r, pixel_pos_nxt;
  logic             layer_full_r, layer_full_nxt;
  logic [PIX_W-1:0] left_r, left_nxt;

  res_t             res_mem_r [2];
  logic             wr_ptr_r, rd_ptr_r;
  logic [1:0]       cnt_r;

  logic             space;
  logic             push;
  res_t             push_res;
  logic             do_pop;
  logic [PIX_W-1:0] clip_n;
  logic [PIX_W-1:0] left_after;

  assign space     = (cnt_r != 2'd2);
  assign out_empty = (cnt_r == 2'd0);
  assign do_pop    = out_pop && !out_empty;
  assign out_res   = res_mem_r[rd_ptr_r];

  assign bk_stat.idle       = (state_r == B_IDLE);
  assign bk_stat.layer_full = layer_full_r;
  assign bk_stat.pixel_pos  = pixel_pos_r;

  always_comb begin
    if (!cmd_r.run_valid) begin
      clip_n = '0;
    end else if (cmd_r.run_len < left_r) begin
      clip_n = cmd_r.run_len;
    end else begin
      clip_n = left_r;
    end
  end

  assign left_after = left_r - clip_n;

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    pixel_pos_nxt  = pixel_pos_r;
    layer_full_nxt = layer_full_r;
    left_nxt       = left_r;
    q_pop          = 1'b0;
    push           = 1'b0;
    push_res       = '0;

    unique case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          q_pop   = 1'b1;
          cmd_nxt = q_head;
          if (q_head.layer_start) begin
            pixel_pos_nxt  = '0;
            layer_full_nxt = q_head.full_now;
          end else begin
            layer_full_nxt = layer_full_r | q_head.full_now;
          end
          state_nxt = B_LEFT;
        end
      end
      B_LEFT: begin
        left_nxt  = (pixel_pos_r < layer_pixels) ? (layer_pixels - pixel_pos_r) : '0;
        state_nxt = B_RUN;
      end
      B_RUN: begin
        if (space) begin
          if (clip_n != '0) begin
            push                = 1'b1;
            push_res.grey_level = grey_of(cmd_r.run_code);
            push_res.run_pixels = clip_n;
            push_res.final_run  = cmd_r.layer_stop && (left_after == '0);
          end
          pixel_pos_nxt = pixel_pos_r + clip_n;
          left_nxt      = left_after;
          if ((left_after == '0) || cmd_r.layer_stop) begin
            layer_full_nxt = 1'b1;
          end
          // a closing byte needs a trailer unless its own run filled the layer
          if (cmd_r.layer_stop && !((clip_n != '0) && (left_after == '0))) begin
            state_nxt = B_END;
          end else begin
            state_nxt = B_IDLE;
          end
        end
      end
      B_END: begin
        if (space) begin
          push                = 1'b1;
          push_res.grey_level = 8'd0;
          push_res.run_pixels = left_r;
          push_res.final_run  = 1'b1;
          pixel_pos_nxt       = pixel_pos_r + left_r;
          layer_full_nxt      = 1'b1;
          state_nxt           = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= B_IDLE;
      pixel_pos_r  <= '0;
      layer_full_r <= 1'b0;
      wr_ptr_r     <= 1'b0;
      rd_ptr_r     <= 1'b0;
      cnt_r        <= 2'd0;
    end else begin
      state_r      <= state_nxt;
      pixel_pos_r  <= pixel_pos_nxt;
      layer_full_r <= layer_full_nxt;
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    left_r <= left_nxt;
    if (push) begin
      res_mem_r[wr_ptr_r] <= push_res;
    end
  end

endmodule

### rtl/keyed_xor_rle_layer_decoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_xor_rle_layer_decoder_unit
// Keyed XOR run-length layer decoder: encoded bytes in, grey pixel runs out.
// ----------------------------------------------------------------------------
// One byte is taken at a time and the next is accepted once the back has
// clipped and queued the previous byte's runs: the byte is accepted and
// decoded in the front, then popped, its remaining pixels computed and its
// run clipped in the back. A layer_begin byte with a nonzero cipher_seed
// first passes through the key derivation, which runs its three
// multiplications through one register each. A layer_end byte that needs a
// closing run adds a trailer step in the back. Results sit in a two-deep
// output queue, so the consumer may leave up to two runs waiting before the
// back stalls; while both entries are taken, the byte inside and the input
// wait until a run is popped. Configuration writes are always ready and take
// effect at once; write them only between layers or while the block is idle.
// ----------------------------------------------------------------------------
module keyed_xor_rle_layer_decoder_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_push,
  output logic                       in_full,
  input  logic [7:0]                 in_code_byte,
  input  logic                       in_layer_begin,
  input  logic                       in_layer_end,
  input  logic [15:0]                in_layer_number,
  output logic                       out_empty,
  input  logic                       out_pop,
  output logic [7:0]                 out_grey_level,
  output logic [kxrd_pkg::PIX_W-1:0] out_run_pixels,
  output logic                       out_final_run,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [kxrd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                cfg_data
);
  import kxrd_pkg::*;

  logic [31:0]      cipher_seed_r;
  logic [PIX_W-1:0] layer_pixels_r;

  cmd_t     q_data;
  cmd_t     q_head;
  logic     q_push, q_pop, q_empty, q_full;
  bk_stat_t bk_stat;
  res_t     out_res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cipher_seed_r  <= '0;
      layer_pixels_r <= PIX_W'(1);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_CIPHER_SEED:  cipher_seed_r  <= cfg_data;
        CFG_LAYER_PIXELS: layer_pixels_r <= cfg_data[PIX_W-1:0];
        default: begin
          // drop writes to unknown registers
        end
      endcase
    end
  end

  kxrd_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_code_byte    (in_code_byte),
    .in_layer_begin  (in_layer_begin),
    .in_layer_end    (in_layer_end),
    .in_layer_number (in_layer_number),
    .cipher_seed     (cipher_seed_r),
    .layer_pixels    (layer_pixels_r),
    .bk_stat         (bk_stat),
    .q_empty         (q_empty),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_data          (q_data)
  );

  kxrd_cmd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_data),
    .pop       (q_pop),
    .head      (q_head),
    .q_empty   (q_empty),
    .q_full    (q_full)
  );

  kxrd_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .layer_pixels (layer_pixels_r),
    .q_head       (q_head),
    .q_empty      (q_empty),
    .q_pop        (q_pop),
    .bk_stat      (bk_stat),
    .out_empty    (out_empty),
    .out_pop      (out_pop),
    .out_res      (out_res)
  );

  assign out_grey_level = out_res.grey_level;
  assign out_run_pixels = out_res.run_pixels;
  assign out_final_run  = out_res.final_run;

endmodule

### tb/sv/keyed_xor_rle_layer_decoder_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_xor_rle_layer_decoder_unit_tb
// Self-checking bench for the keyed XOR run-length layer decoder.
// ----------------------------------------------------------------------------
// Encoded layers are built as plaintext runs, encrypted with the key stream
// the bench tracks itself, and pushed through the byte queue interface with
// random gaps. A bit-accurate decoder model in this file predicts every run
// when its byte is accepted; a separate sink pops runs with random stalls and
// compares them in order. Directed layers cover the stream forms, layer close
// cases, encryption, size changes and bytes before any layer, then random
// layers, broken layers and noise run under changing key and size settings.
// ----------------------------------------------------------------------------
module keyed_xor_rle_layer_decoder_unit_tb;
  import kxrd_pkg::*;

  localparam int SETTLE_CYCLES = 24;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int RANDOM_BYTES  = 860;

  typedef enum logic [1:0] {PH_CODE, PH_LEN, PH_EXT} parse_e;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_push;
  logic                 in_full;
  logic [7:0]           in_code_byte;
  logic                 in_layer_begin;
  logic                 in_layer_end;
  logic [15:0]          in_layer_number;
  logic                 out_empty;
  logic                 out_pop;
  logic [7:0]           out_grey_level;
  logic [PIX_W-1:0]     out_run_pixels;
  logic                 out_final_run;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0]          cfg_data;

  keyed_xor_rle_layer_decoder_unit u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_code_byte    (in_code_byte),
    .in_layer_begin  (in_layer_begin),
    .in_layer_end    (in_layer_end),
    .in_layer_number (in_layer_number),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_grey_level  (out_grey_level),
    .out_run_pixels  (out_run_pixels),
    .out_final_run   (out_final_run),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #5 clk = ~clk;

  // Decoder model state
  logic [31:0]      seed_reg;
  logic [PIX_W-1:0] pixels_reg;
  logic [31:0]      key_word;
  logic [31:0]      key_step;
  logic [1:0]       key_pos;
  logic [PIX_W-1:0] pix_pos;
  parse_e           phase;
  logic [6:0]       held_code;
  logic [PIX_W-1:0] len_acc;
  logic [1:0]       ext_left;
  logic             layer_done;

  res_t runs_due[$];
  res_t step_runs[2];
  int   step_count;
  bit   byte_used;

  logic [7:0] plain_q[$];

  int err_count      = 0;
  int bytes_taken    = 0;
  int useful_bytes   = 0;
  int runs_seen      = 0;
  int layers_started = 0;
  int cycle_count    = 0;
  int sink_hold      = 0;
  bit src_eager      = 1'b0;
  int stretch_left[2]  = '{0, 0};
  bit stretch_quiet[2] = '{1'b0, 1'b0};

  // Wait drawn per beat; stretches of zero wait come up now and then
  function automatic int draw_wait(input bit sink);
    if (!sink && src_eager) return 0;
    if (stretch_left[sink] == 0) begin
      stretch_left[sink]  = $urandom_range(8, 60);
      stretch_quiet[sink] = ($urandom_range(0, 3) == 0);
    end
    stretch_left[sink]--;
    return stretch_quiet[sink] ? 0 : $urandom_range(0, 13);
  endfunction

  function automatic logic [7:0] rand8();
    logic [7:0] v;
    v = 8'($urandom());
    return v;
  endfunction

  function automatic logic [15:0] rand16();
    logic [15:0] v;
    v = 16'($urandom());
    return v;
  endfunction

  function automatic logic [31:0] step_of(input logic [31:0] s);
    return s * STEP_MUL + STEP_ADD;
  endfunction

  function automatic logic [31:0] word_of(input logic [15:0] layer, input logic [31:0] stp);
    return ({16'd0, layer} * LAYER_MUL + LAYER_ADD) * stp;
  endfunction

  function automatic logic [PIX_W-1:0] pixels_left();
    return (pix_pos < pixels_reg) ? pixels_reg - pix_pos : '0;
  endfunction

  // Key byte that the next accepted byte will be XORed with
  function automatic logic [7:0] key_ahead(input logic first, input logic [15:0] layer);
    logic [31:0] w;
    if (!first) w = key_word >> (8 * key_pos);
    else if (seed_reg == '0) w = '0;
    else w = word_of(layer, step_of(seed_reg));
    return w[7:0];
  endfunction

  task automatic model_reset();
    seed_reg   = '0;
    pixels_reg = PIX_W'(1);
    key_word   = '0;
    key_step   = '0;
    key_pos    = '0;
    pix_pos    = '0;
    phase      = PH_CODE;
    held_code  = '0;
    len_acc    = '0;
    ext_left   = '0;
    layer_done = 1'b0;
    runs_due.delete();
  endtask

  // Clip a run to the pixels left; drop it if nothing is left
  task automatic emit_run(input logic [6:0] code, input logic [PIX_W-1:0] len);
    logic [PIX_W-1:0] left;
    logic [PIX_W-1:0] n;
    left = pixels_left();
    n = (len < left) ? len : left;
    if (n != '0) begin
      pix_pos = pix_pos + n;
      if (pixels_left() == '0) layer_done = 1'b1;
      step_runs[step_count].grey_level = (code == 7'd0) ? 8'd0 : {code, 1'b1};
      step_runs[step_count].run_pixels = n;
      step_runs[step_count].final_run  = 1'b0;
      step_count++;
    end
  endtask

  task automatic decode_byte(input logic [7:0] raw, input logic first, input logic last,
                             input logic [15:0] layer);
    logic [7:0]       b;
    logic [PIX_W-1:0] left;
    step_count = 0;
    if (first) begin
      pix_pos    = '0;
      phase      = PH_CODE;
      held_code  = '0;
      len_acc    = '0;
      ext_left   = '0;
      layer_done = 1'b0;
      key_pos    = '0;
      key_step   = (seed_reg != '0) ? step_of(seed_reg) : '0;
      key_word   = (seed_reg != '0) ? word_of(layer, key_step) : '0;
      layers_started++;
    end
    if (pixels_left() == '0) layer_done = 1'b1;
    byte_used = !layer_done || last;
    if (!layer_done) begin
      b = raw ^ key_word[8*key_pos +: 8];
      key_pos = key_pos + 2'd1;
      if (key_pos == 2'd0) key_word = key_word + key_step;
      case (phase)
        PH_CODE: begin
          if (!b[7]) emit_run(b[6:0], PIX_W'(1));
          else begin
            held_code = b[6:0];
            phase = PH_LEN;
          end
        end
        PH_LEN: begin
          casez (b)
            8'b0???????: begin
              phase = PH_CODE;
              emit_run(held_code, PIX_W'(b[6:0]));
            end
            8'b10??????: begin
              len_acc = PIX_W'(b[5:0]);
              ext_left = 2'd1;
              phase = PH_EXT;
            end
            8'b110?????: begin
              len_acc = PIX_W'(b[4:0]);
              ext_left = 2'd2;
              phase = PH_EXT;
            end
            8'b1110????: begin
              len_acc = PIX_W'(b[3:0]);
              ext_left = 2'd3;
              phase = PH_EXT;
            end
            default: begin
              phase = PH_CODE;
              emit_run(held_code, PIX_W'(1));
            end
          endcase
        end
        default: begin
          len_acc = {len_acc[PIX_W-9:0], b};
          ext_left = ext_left - 2'd1;
          if (ext_left == 2'd0) begin
            phase = PH_CODE;
            emit_run(held_code, len_acc);
          end
        end
      endcase
    end
    if (last) begin
      // drop any partial code, fill the remainder, flag the closing run
      left = pixels_left();
      phase = PH_CODE;
      len_acc = '0;
      ext_left = '0;
      if (left != '0) emit_run(7'd0, left);
      else if (step_count == 0) begin
        step_runs[0] = '0;
        step_count = 1;
      end
      step_runs[step_count-1].final_run = 1'b1;
      layer_done = 1'b1;
    end
    for (int i = 0; i < step_count; i++) runs_due.push_back(step_runs[i]);
  endtask

  task automatic push_byte(input logic [7:0] data, input logic first, input logic last,
                           input logic [15:0] layer);
    int gap;
    gap = draw_wait(1'b0);
    repeat (gap) begin
      @(negedge clk);
      in_push <= 1'b0;
    end
    @(negedge clk);
    in_push         <= 1'b1;
    in_code_byte    <= data;
    in_layer_begin  <= first;
    in_layer_end    <= last;
    in_layer_number <= layer;
    @(posedge clk);
    while (in_full) @(posedge clk);
    decode_byte(data, first, last, layer);
    bytes_taken++;
    if (byte_used) useful_bytes++;
  endtask

  task automatic send_plain(input logic [7:0] plain, input logic first, input logic last,
                            input logic [15:0] layer);
    push_byte(plain ^ key_ahead(first, layer), first, last, layer);
  endtask

  // Send plain_q as one layer; the layer number only matters on the first beat
  task automatic send_q(input logic [15:0] layer, input bit closed);
    int last_i;
    last_i = plain_q.size() - 1;
    foreach (plain_q[i])
      send_plain(plain_q[i], i == 0, closed && (i == last_i), (i == 0) ? layer : rand16());
  endtask

  task automatic settle();
    @(negedge clk);
    in_push <= 1'b0;
    while (runs_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_CIPHER_SEED) seed_reg = val;
    else if (idx == CFG_LAYER_PIXELS) pixels_reg = val[PIX_W-1:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic check_run();
    res_t want;
    runs_seen++;
    if (runs_due.size() == 0) begin
      $error("unexpected run: grey_level %0d run_pixels %0d final_run %0d",
             out_grey_level, out_run_pixels, out_final_run);
      err_count++;
    end else begin
      want = runs_due.pop_front();
      if (out_grey_level !== want.grey_level) begin
        $error("grey_level: expected %0d, got %0d", want.grey_level, out_grey_level);
        err_count++;
      end
      if (out_run_pixels !== want.run_pixels) begin
        $error("run_pixels: expected %0d, got %0d", want.run_pixels, out_run_pixels);
        err_count++;
      end
      if (out_final_run !== want.final_run) begin
        $error("final_run: expected %0d, got %0d", want.final_run, out_final_run);
        err_count++;
      end
    end
  endtask

  // Append one random code, with one of the length forms
  task automatic add_token();
    int         pick;
    bit         wide;
    logic [6:0] code;
    logic [7:0] r;
    pick = $urandom_range(0, 99);
    wide = ($urandom_range(0, 3) == 0);
    code = 7'($urandom());
    r    = 8'($urandom());
    if (pick < 35) plain_q.push_back({1'b0, code});
    else begin
      plain_q.push_back({1'b1, code});
      if (pick < 60) plain_q.push_back({1'b0, r[6:0]});
      else if (pick < 70) plain_q.push_back({4'hF, r[3:0]});
      else if (pick < 82) begin
        plain_q.push_back({2'b10, wide ? r[5:0] : 6'd0});
        plain_q.push_back(rand8());
      end else if (pick < 91) begin
        plain_q.push_back({3'b110, wide ? r[4:0] : 5'd0});
        plain_q.push_back(wide ? rand8() : 8'd0);
        plain_q.push_back(rand8());
      end else begin
        plain_q.push_back({4'hE, wide ? r[3:0] : 4'd0});
        plain_q.push_back(wide ? rand8() : 8'd0);
        plain_q.push_back(wide ? rand8() : 8'd0);
        plain_q.push_back(rand8());
      end
    end
  endtask

  task automatic send_layer();
    int target;
    int cut;
    bit closed;
    plain_q.delete();
    target = $urandom_range(1, 40);
    while (plain_q.size() < target) add_token();
    // broken layers: stop mid-code, or never close
    if ($urandom_range(0, 5) == 0) begin
      cut = $urandom_range(1, plain_q.size());
      while (plain_q.size() > cut) plain_q.delete(plain_q.size() - 1);
    end
    closed = ($urandom_range(0, 7) != 0);
    send_q(rand16(), closed);
  endtask

  task automatic send_noise();
    int n;
    n = $urandom_range(1, 5);
    repeat (n)
      push_byte(rand8(), $urandom_range(0, 5) == 0, $urandom_range(0, 5) == 0, rand16());
  endtask

  task automatic test_before_first_layer();
    // reset state decodes: one pixel fills the layer, then a bare close
    push_byte(8'h05, 1'b0, 1'b0, 16'h0000);
    push_byte(8'h22, 1'b0, 1'b1, 16'hFFFF);
  endtask

  task automatic test_stream_forms();
    settle();
    write_reg(CFG_CIPHER_SEED, 32'h0);
    write_reg(CFG_LAYER_PIXELS, 32'd40);
    // short codes, empty run, 0xF0 prefix, 14/21/28-bit lengths, partial code at close
    plain_q = '{8'h00, 8'h7F, 8'h81, 8'h00, 8'hC5, 8'hF7, 8'h83, 8'h80, 8'h05,
                8'h84, 8'hC0, 8'h00, 8'h03, 8'h85, 8'hE0, 8'h00, 8'h00, 8'h02, 8'h87};
    send_q(16'h0000, 1'b1);
  endtask

  task automatic test_layer_close();
    settle();
    write_reg(CFG_LAYER_PIXELS, 32'd2);
    plain_q = '{8'h01, 8'h02};
    send_q(16'h0001, 1'b1);
    plain_q = '{8'h03, 8'h04, 8'h05};
    send_q(16'h0002, 1'b1);
    plain_q = '{8'h06};
    send_q(16'h0003, 1'b1);
  endtask

  task automatic test_encrypted();
    settle();
    write_reg(CFG_CIPHER_SEED, 32'hFFFF_FFFF);
    write_reg(CFG_LAYER_PIXELS, 32'd8);
    plain_q = '{8'h42};
    send_q(16'hFFFF, 1'b1);
    // five beats cross the key add
    plain_q = '{8'h01, 8'h02, 8'h03, 8'h04, 8'h05};
    send_q(16'h0000, 1'b1);
  endtask

  task automatic test_resize_mid_layer();
    settle();
    write_reg(CFG_CIPHER_SEED, 32'h1);
    write_reg(CFG_LAYER_PIXELS, 32'd40);
    plain_q = '{8'h01, 8'h01};
    send_q(16'h1234, 1'b0);
    settle();
    write_reg(CFG_LAYER_PIXELS, 32'd1);
    send_plain(8'h05, 1'b0, 1'b1, 16'h0000);
    settle();
    write_reg(CFG_LAYER_PIXELS, 32'd0);
    send_plain(8'h07, 1'b1, 1'b1, 16'h4321);
  endtask

  task automatic test_backpressure();
    settle();
    write_reg(CFG_CIPHER_SEED, $urandom());
    write_reg(CFG_LAYER_PIXELS, 32'h0FFF_FFFF);
    src_eager = 1'b1;
    sink_hold = 300;
    plain_q.delete();
    repeat (48) plain_q.push_back(rand8() >> 1);
    send_q(rand16(), 1'b1);
    src_eager = 1'b0;
  endtask

  task automatic test_random_layers();
    int         start;
    int         layers_n;
    logic [31:0] s;
    logic [31:0] p;
    start = bytes_taken;
    while (bytes_taken - start < RANDOM_BYTES) begin
      settle();
      case ($urandom_range(0, 3))
        0:       s = 32'h0;
        1:       s = 32'hFFFF_FFFF;
        default: s = $urandom();
      endcase
      case ($urandom_range(0, 9))
        0:       p = 1;
        1:       p = 32'h0FFF_FFFF;
        2, 3:    p = $urandom_range(1, 8);
        4, 5, 6: p = $urandom_range(1, 300);
        default: p = $urandom_range(1, 5000);
      endcase
      write_reg(CFG_CIPHER_SEED, s);
      write_reg(CFG_LAYER_PIXELS, p);
      layers_n = $urandom_range(2, 6);
      repeat (layers_n) begin
        if ($urandom_range(0, 4) == 0) send_noise();
        else send_layer();
      end
    end
  endtask

  initial begin : result_sink
    int wait_n;
    out_pop = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (sink_hold > 0) begin
        // long hold so the block backs up into its input
        wait_n = sink_hold;
        sink_hold = 0;
        repeat (wait_n) begin
          @(negedge clk);
          out_pop <= 1'b0;
        end
      end
      wait_n = draw_wait(1'b1);
      repeat (wait_n) begin
        @(negedge clk);
        out_pop <= 1'b0;
      end
      @(negedge clk);
      out_pop <= 1'b1;
      @(posedge clk);
      while (out_empty) @(posedge clk);
      check_run();
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timed out after %0d cycles, %0d runs still due", cycle_count, runs_due.size());
    $display("FAILURE");
    $finish;
  end

  initial begin : main
    int guard;
    rst_n           = 1'b0;
    in_push         = 1'b0;
    in_code_byte    = '0;
    in_layer_begin  = 1'b0;
    in_layer_end    = 1'b0;
    in_layer_number = '0;
    cfg_valid       = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    model_reset();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_before_first_layer();
    test_stream_forms();
    test_layer_close();
    test_encrypted();
    test_resize_mid_layer();
    test_backpressure();
    test_random_layers();

    @(negedge clk);
    in_push <= 1'b0;
    guard = 0;
    while (runs_due.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (runs_due.size() != 0) begin
      $error("%0d runs never arrived", runs_due.size());
      err_count++;
    end
    $display("Decoded %0d bytes (%0d inside open layers, %0d layer starts) into %0d runs.",
             bytes_taken, useful_bytes, layers_started, runs_seen);
    $display("Covered plain and keyed layers, all length forms, size changes and a full stall.");
    if (err_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
